/* design/smie_pkg.sv */
`timescale 1ns / 1ps
// Shared types, opcodes and status codes of the stack machine execute unit.
// No dependencies; every other design file imports this package.
package smie_pkg;

   // default sizes handed to the top level
   localparam int STACK_DEPTH_DEF = 256;
   localparam int MAX_LOCALS_DEF  = 64;
   localparam int DATA_W          = 64;

   // opcodes and the first code of each opcode group
   localparam logic [5:0] OP_NOP      = 6'd0;
   localparam logic [5:0] OP_BR       = 6'd1;
   localparam logic [5:0] OP_BR_TRUE  = 6'd2;
   localparam logic [5:0] OP_BR_ZERO  = 6'd3;
   localparam logic [5:0] OP_POP      = 6'd4;
   localparam logic [5:0] OP_DUP      = 6'd5;
   localparam logic [5:0] OP_LGET     = 6'd6;
   localparam logic [5:0] OP_LSET     = 6'd7;
   localparam logic [5:0] OP_CONST    = 6'd8;
   localparam logic [5:0] OP_EQZ      = 6'd9;
   localparam logic [5:0] OP_CMP32    = 6'd10;
   localparam logic [5:0] OP_CMP64    = 6'd20;
   localparam logic [5:0] OP_ALU32    = 6'd30;
   localparam logic [5:0] OP_ALU64    = 6'd43;
   localparam logic [5:0] OP_LAST     = 6'd55;

   // compare variants, in opcode order
   localparam logic [3:0] CMP_EQ  = 4'd0;
   localparam logic [3:0] CMP_NE  = 4'd1;
   localparam logic [3:0] CMP_LT  = 4'd2;
   localparam logic [3:0] CMP_LTU = 4'd3;
   localparam logic [3:0] CMP_GT  = 4'd4;
   localparam logic [3:0] CMP_GTU = 4'd5;
   localparam logic [3:0] CMP_LE  = 4'd6;
   localparam logic [3:0] CMP_LEU = 4'd7;
   localparam logic [3:0] CMP_GE  = 4'd8;

   // alu variants, in opcode order
   localparam logic [3:0] ALU_ADD  = 4'd0;
   localparam logic [3:0] ALU_SUB  = 4'd1;
   localparam logic [3:0] ALU_MUL  = 4'd2;
   localparam logic [3:0] ALU_DIV  = 4'd3;
   localparam logic [3:0] ALU_DIVU = 4'd4;
   localparam logic [3:0] ALU_REM  = 4'd5;
   localparam logic [3:0] ALU_REMU = 4'd6;
   localparam logic [3:0] ALU_AND  = 4'd7;
   localparam logic [3:0] ALU_OR   = 4'd8;
   localparam logic [3:0] ALU_XOR  = 4'd9;
   localparam logic [3:0] ALU_SHL  = 4'd10;
   localparam logic [3:0] ALU_SHR  = 4'd11;

   // result status codes
   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_DIV0   = 3'd1;
   localparam logic [2:0] STAT_UNDER  = 3'd2;
   localparam logic [2:0] STAT_OVER   = 3'd3;
   localparam logic [2:0] STAT_BADLOC = 3'd4;

   // instruction class found by the front end
   typedef enum logic [3:0] {
      KIND_NOP,
      KIND_BR,
      KIND_BRC,
      KIND_POP,
      KIND_DUP,
      KIND_LGET,
      KIND_LSET,
      KIND_CONST,
      KIND_EQZ,
      KIND_CMP,
      KIND_ALU
   } smie_kind_type;

   // classified instruction handed from front to back
   typedef struct packed {
      smie_kind_type       kind;
      logic [3:0]          sub;
      logic                narrow;
      logic                br_true;
      logic [DATA_W-1:0]   imm;
   } smie_item_type;

endpackage

/* design/smie_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request beats, classifies the opcode and queues the
// classified instruction for the back end. Depends on smie_pkg.
module smie_front
   import smie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [5:0]    req_op,
   input  logic [63:0]   req_imm,
   output logic          item_valid,
   input  logic          item_ready,
   output smie_item_type item
);

   smie_item_type entry_ff [2];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    count_ff, count_in;
   smie_item_type dec;
   logic          push, pop;

   // classify the opcode
   always_comb begin
      dec         = '0;
      dec.imm     = req_imm;
      dec.kind    = KIND_NOP;
      dec.br_true = (req_op == OP_BR_TRUE);
      case (req_op)
         OP_NOP:      dec.kind = KIND_NOP;
         OP_BR:       dec.kind = KIND_BR;
         OP_BR_TRUE:  dec.kind = KIND_BRC;
         OP_BR_ZERO:  dec.kind = KIND_BRC;
         OP_POP:      dec.kind = KIND_POP;
         OP_DUP:      dec.kind = KIND_DUP;
         OP_LGET:     dec.kind = KIND_LGET;
         OP_LSET:     dec.kind = KIND_LSET;
         OP_CONST:    dec.kind = KIND_CONST;
         OP_EQZ:      dec.kind = KIND_EQZ;
         default: begin
            if (req_op >= OP_CMP32 && req_op < OP_CMP64) begin
               dec.kind   = KIND_CMP;
               dec.narrow = 1'b1;
               dec.sub    = 4'(req_op - OP_CMP32);
            end else if (req_op >= OP_CMP64 && req_op < OP_ALU32) begin
               dec.kind = KIND_CMP;
               dec.sub  = 4'(req_op - OP_CMP64);
            end else if (req_op >= OP_ALU32 && req_op < OP_ALU64) begin
               dec.kind   = KIND_ALU;
               dec.narrow = 1'b1;
               dec.sub    = 4'(req_op - OP_ALU32);
            end else if (req_op >= OP_ALU64 && req_op <= OP_LAST) begin
               dec.kind = KIND_ALU;
               dec.sub  = 4'(req_op - OP_ALU64);
            end
         end
      endcase
   end

   // two-entry queue between front and back
   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // hold queued beats
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= dec;
      end
   end

endmodule

/* design/smie_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// Depends on smie_pkg for nothing beyond the house import.
module smie_div
   import smie_pkg::*;
#(
   parameter int W = DATA_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W:0]    r_ff, r_in;
   logic [W:0]    d_ff, d_in;
   logic [W:0]    r_sh;

   // shift in one dividend bit and try the subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      r_sh    = {r_ff[W-1:0], q_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
         d_in    = {1'b0, divisor};
      end else if (busy_ff) begin
         if (r_sh >= d_ff) begin
            r_in = r_sh - d_ff;
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff[W-1:0];

endmodule

/* design/smie_back.sv */
`timescale 1ns / 1ps
// Back end: stack memory, stack pointer, execute sequencer, multiplier,
// divider and the result register. Depends on smie_pkg and smie_div.
module smie_back
   import smie_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_LOCALS  = MAX_LOCALS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  smie_item_type item,
   input  logic          csr_write,
   input  logic [6:0]    csr_locals_count,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_top_value,
   output logic [8:0]    rsp_stack_depth,
   output logic          rsp_branch_taken,
   output logic [2:0]    rsp_status
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int LIM  = (MAX_LOCALS < STACK_DEPTH) ? MAX_LOCALS : STACK_DEPTH;
   localparam logic [63:0] SBIT64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] SBIT32 = 64'h0000_0000_8000_0000;
   localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_BRC  = 12'b0000_0000_0010,
      S_PUSH = 12'b0000_0000_0100,
      S_LSET = 12'b0000_0000_1000,
      S_EQZ  = 12'b0000_0001_0000,
      S_RDB  = 12'b0000_0010_0000,
      S_EXEC = 12'b0000_0100_0000,
      S_MUL  = 12'b0000_1000_0000,
      S_DIV  = 12'b0001_0000_0000,
      S_WRR  = 12'b0010_0000_0000,
      S_TOP  = 12'b0100_0000_0000,
      S_FIN  = 12'b1000_0000_0000
   } smie_state_type;

   smie_state_type state_ff, state_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [SP_W-1:0] lc_ff, lc_in;
   smie_item_type   cur_ff, cur_in;
   logic [63:0]     a_ff, a_in;
   logic [63:0]     b_ff, b_in;
   logic [63:0]     res_ff, res_in;
   logic [63:0]     prod_ff, prod_in;
   logic [63:0]     acc_ff, acc_in;
   logic [1:0]      mcnt_ff, mcnt_in;
   logic            taken_ff, taken_in;
   logic [2:0]      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_top_ff, rsp_top_in;
   logic [8:0]      rsp_depth_ff, rsp_depth_in;
   logic            rsp_taken_ff, rsp_taken_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;

   // stack memory
   logic [63:0]     mem [STACK_DEPTH];
   logic [63:0]     rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [63:0]     mem_wd;

   // stack checks and addresses
   logic            avail1, avail2, full, bad_cur, bad_new;
   logic [SP_W-1:0] spm1_w, spm2_w;
   logic [AW-1:0]   spm1, spm2, sp_a;
   logic [31:0]     depth32;

   // execute datapath
   logic [63:0]     am, bm, bsrc, sbit, ua_s, ub_s, ma, mb;
   logic [5:0]      sh;
   logic [31:0]     sra32;
   logic [63:0]     alu_r, cmp_r, div_r;
   logic            eq, lts, ltu, cmp_bit, na, nb, sgn;
   logic [31:0]     mx, my;
   logic            div_start, div_done;
   logic [63:0]     div_quot, div_rem;

   smie_div #(.W(DATA_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ma),
      .divisor  (mb),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign spm1_w = sp_ff - SP_W'(1);
   assign spm2_w = sp_ff - SP_W'(2);
   assign spm1   = spm1_w[AW-1:0];
   assign spm2   = spm2_w[AW-1:0];
   assign sp_a   = sp_ff[AW-1:0];
   assign avail1 = sp_ff > lc_ff;
   assign avail2 = {1'b0, sp_ff} > ({1'b0, lc_ff} + (SP_W + 1)'(1));
   assign full   = sp_ff >= SP_W'(STACK_DEPTH);
   assign bad_new = item.imm >= 64'(lc_ff);
   assign bad_cur = cur_ff.imm >= 64'(lc_ff);
   assign depth32 = 32'(sp_ff);

   // operands of the binary operations: a from the register, b from memory
   // in the execute cycle and from its register afterwards
   always_comb begin
      bsrc  = state_ff[6] ? rd_ff : b_ff;
      am    = cur_ff.narrow ? (a_ff & MASK32) : a_ff;
      bm    = cur_ff.narrow ? (bsrc & MASK32) : bsrc;
      sbit  = cur_ff.narrow ? SBIT32 : SBIT64;
      sh    = cur_ff.narrow ? {1'b0, bsrc[4:0]} : bsrc[5:0];
      sra32 = 32'($signed(am[31:0]) >>> sh);
      na    = (am & sbit) != 64'd0;
      nb    = (bm & sbit) != 64'd0;
      sgn   = (cur_ff.sub == ALU_DIV) || (cur_ff.sub == ALU_REM);
      ma    = (sgn && na) ? ((64'd0 - am) & (cur_ff.narrow ? MASK32 : ~64'd0)) : am;
      mb    = (sgn && nb) ? ((64'd0 - bm) & (cur_ff.narrow ? MASK32 : ~64'd0)) : bm;
   end

   // simple alu operations
   always_comb begin
      case (cur_ff.sub)
         ALU_ADD:  alu_r = am + bm;
         ALU_SUB:  alu_r = am - bm;
         ALU_AND:  alu_r = am & bm;
         ALU_OR:   alu_r = am | bm;
         ALU_XOR:  alu_r = am ^ bm;
         ALU_SHL:  alu_r = am << sh;
         ALU_SHR:  alu_r = cur_ff.narrow ? {32'd0, sra32} : 64'($signed(am) >>> sh);
         default:  alu_r = am >> sh;
      endcase
   end

   // compares, signed ones by flipping the sign bit
   always_comb begin
      ua_s = am ^ sbit;
      ub_s = bm ^ sbit;
      eq   = am == bm;
      ltu  = am < bm;
      lts  = ua_s < ub_s;
      case (cur_ff.sub)
         CMP_EQ:  cmp_bit = eq;
         CMP_NE:  cmp_bit = !eq;
         CMP_LT:  cmp_bit = lts;
         CMP_LTU: cmp_bit = ltu;
         CMP_GT:  cmp_bit = !lts && !eq;
         CMP_GTU: cmp_bit = !ltu && !eq;
         CMP_LE:  cmp_bit = lts || eq;
         CMP_LEU: cmp_bit = ltu || eq;
         CMP_GE:  cmp_bit = !lts;
         default: cmp_bit = !ltu;
      endcase
      cmp_r = {63'd0, cmp_bit};
   end

   // sign fix of quotient and remainder
   always_comb begin
      if (cur_ff.sub == ALU_DIV || cur_ff.sub == ALU_DIVU) begin
         div_r = (sgn && (na != nb)) ? (64'd0 - div_quot) : div_quot;
      end else begin
         div_r = (sgn && na) ? (64'd0 - div_rem) : div_rem;
      end
   end

   // multiplier operand selection: low-low, low-high, high-low
   always_comb begin
      case (mcnt_ff)
         2'd0:    begin mx = a_ff[31:0];  my = b_ff[31:0];  end
         2'd1:    begin mx = a_ff[31:0];  my = b_ff[63:32]; end
         default: begin mx = a_ff[63:32]; my = b_ff[31:0];  end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      lc_in         = lc_ff;
      cur_in        = cur_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      prod_in       = mx * my;
      acc_in        = acc_ff;
      mcnt_in       = mcnt_ff;
      taken_in      = taken_ff;
      status_in     = status_ff;
      item_ready    = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = sp_a;
      mem_wd        = rd_ff;
      mem_ra        = spm1;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_ready = 1'b1;
               cur_in     = item;
               taken_in   = 1'b0;
               status_in  = STAT_OK;
               state_in   = S_TOP;
               case (item.kind)
                  KIND_BR: taken_in = 1'b1;
                  KIND_BRC: begin
                     if (!avail1) status_in = STAT_UNDER;
                     else state_in = S_BRC;
                  end
                  KIND_POP: begin
                     if (!avail1) status_in = STAT_UNDER;
                     else sp_in = spm1_w;
                  end
                  KIND_DUP: begin
                     if (!avail1) status_in = STAT_UNDER;
                     else if (full) status_in = STAT_OVER;
                     else state_in = S_PUSH;
                  end
                  KIND_LGET: begin
                     mem_ra = item.imm[AW-1:0];
                     if (bad_new) status_in = STAT_BADLOC;
                     else if (full) status_in = STAT_OVER;
                     else state_in = S_PUSH;
                  end
                  KIND_LSET: begin
                     if (bad_new) status_in = STAT_BADLOC;
                     else if (!avail1) status_in = STAT_UNDER;
                     else state_in = S_LSET;
                  end
                  KIND_CONST: begin
                     if (full) begin
                        status_in = STAT_OVER;
                     end else begin
                        mem_we = 1'b1;
                        mem_wd = item.imm;
                        sp_in  = sp_ff + SP_W'(1);
                     end
                  end
                  KIND_EQZ: begin
                     if (!avail1) status_in = STAT_UNDER;
                     else state_in = S_EQZ;
                  end
                  KIND_CMP, KIND_ALU: begin
                     mem_ra = spm2;
                     if (!avail2) status_in = STAT_UNDER;
                     else state_in = S_RDB;
                  end
                  default: ;
               endcase
            end
         end
         S_BRC: begin
            taken_in = cur_ff.br_true ? (rd_ff[31:0] != 32'd0) : (rd_ff[31:0] == 32'd0);
            sp_in    = spm1_w;
            state_in = S_TOP;
         end
         S_PUSH: begin
            mem_we   = 1'b1;
            sp_in    = sp_ff + SP_W'(1);
            state_in = S_TOP;
         end
         S_LSET: begin
            mem_we   = !bad_cur;
            mem_wa   = cur_ff.imm[AW-1:0];
            sp_in    = spm1_w;
            state_in = S_TOP;
         end
         S_EQZ: begin
            mem_we   = 1'b1;
            mem_wa   = spm1;
            mem_wd   = {rd_ff[63:32], 31'd0, rd_ff[31:0] == 32'd0};
            state_in = S_TOP;
         end
         S_RDB: begin
            a_in     = rd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            b_in = rd_ff;
            if (cur_ff.kind == KIND_CMP) begin
               res_in   = cur_ff.narrow ? {a_ff[63:32], cmp_r[31:0]} : cmp_r;
               state_in = S_WRR;
            end else if (cur_ff.sub == ALU_MUL) begin
               mcnt_in  = 2'd0;
               state_in = S_MUL;
            end else if (cur_ff.sub == ALU_DIV || cur_ff.sub == ALU_DIVU
                         || cur_ff.sub == ALU_REM || cur_ff.sub == ALU_REMU) begin
               if (bm == 64'd0) begin
                  status_in = STAT_DIV0;
                  state_in  = S_TOP;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               res_in   = cur_ff.narrow ? {a_ff[63:32], alu_r[31:0]} : alu_r;
               state_in = S_WRR;
            end
         end
         S_MUL: begin
            // accumulate the three partial products
            mcnt_in = mcnt_ff + 2'd1;
            case (mcnt_ff)
               2'd0:    ;
               2'd1:    acc_in = prod_ff;
               2'd2:    acc_in = acc_ff + {prod_ff[31:0], 32'd0};
               default: begin
                  acc_in   = acc_ff + {prod_ff[31:0], 32'd0};
                  res_in   = cur_ff.narrow ? {a_ff[63:32], acc_ff[31:0]} : acc_in;
                  state_in = S_WRR;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = cur_ff.narrow ? {a_ff[63:32], div_r[31:0]} : div_r;
               state_in = S_WRR;
            end
         end
         S_WRR: begin
            mem_we   = 1'b1;
            mem_wa   = spm2;
            mem_wd   = res_ff;
            sp_in    = spm1_w;
            state_in = S_TOP;
         end
         S_TOP: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (sp_ff == '0) ? 64'd0 : rd_ff;
               rsp_depth_in  = depth32[8:0];
               rsp_taken_in  = taken_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // start a new frame on a register write
      if (csr_write) begin
         lc_in = (32'(csr_locals_count) > LIM) ? SP_W'(LIM) : SP_W'(csr_locals_count);
         sp_in = lc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mcnt_ff       <= mcnt_in;
      taken_ff      <= taken_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_value    = rsp_top_ff;
   assign rsp_stack_depth  = rsp_depth_ff;
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* design/stack_machine_integer_execute.sv */
`timescale 1ns / 1ps
// Integer execute unit of an operand-stack machine: one decoded instruction
// per request beat, one result beat per instruction. A two-entry queue parts
// the front end from the sequencer, so requests are taken while the back end
// works. One instruction at a time is executed against a stack memory with
// one write port and one registered read port (one write and one read per
// cycle). Multiply forms three 32x32 partial products on one multiplier;
// divide and remainder produce one quotient bit per cycle. The stack memory
// is not cleared after reset; reading a local never written gives an
// undefined value.
// Depends on smie_pkg, smie_front, smie_back and smie_div.
module stack_machine_integer_execute
   import smie_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_LOCALS  = MAX_LOCALS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [5:0]         req_op,
   input  logic signed [63:0] req_imm,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_top_value,
   output logic [8:0]         rsp_stack_depth,
   output logic               rsp_branch_taken,
   output logic [2:0]         rsp_status,
   input  logic               csr_write,
   input  logic [6:0]         csr_locals_count
);

   logic          item_valid;
   logic          item_ready;
   smie_item_type item;
   logic [63:0]   top_value;

   smie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_imm    (req_imm),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   smie_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LOCALS  (MAX_LOCALS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_ready       (item_ready),
      .item             (item),
      .csr_write        (csr_write),
      .csr_locals_count (csr_locals_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_value    (top_value),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_status       (rsp_status)
   );

   assign rsp_top_value = $signed(top_value);

endmodule

/* design/smie_chk.sv */
`timescale 1ns / 1ps
// Port checker for the execute unit, bound to the top level.
// Depends on smie_pkg for the status codes.
module smie_chk
   import smie_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [5:0]         req_op,
   input logic signed [63:0] req_imm,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [63:0] rsp_top_value,
   input logic [8:0]         rsp_stack_depth,
   input logic               rsp_branch_taken,
   input logic [2:0]         rsp_status
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_op)
         && $stable(req_imm)))
      else $error("stalled request beat changed");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_stack_depth) && $stable(rsp_status)))
      else $error("stalled result beat changed");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_DIV0
         || rsp_status == STAT_UNDER || rsp_status == STAT_OVER
         || rsp_status == STAT_BADLOC))
      else $error("undefined status code");

   // a taken branch never comes with a failed check
   a_taken_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_branch_taken) |-> (rsp_status == STAT_OK))
      else $error("branch taken with error status");

endmodule

bind stack_machine_integer_execute smie_chk u_chk (.*);
